FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the placement checker.
// Stand-alone header; no other file is needed to use it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the reset is high.
`define CPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// The same on the block's own clock and reset.
`define CPC_ASSERT_CLK(label, prop, msg) \
   `CPC_ASSERT(label, clock, reset, prop, msg)

`endif

FILE: rtl/cpc_pkg.sv
// Shared types, sizes and codes of the circle placement checker.
// Used by the cell, the top level and the checker; depends on nothing.
`default_nettype none

package cpc_pkg;

   // Store size and the way it is split over the row of cells.
   localparam int CAPACITY    = 1024;
   localparam int NUM_CELLS   = 8;
   localparam int CELL_SEL_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int BANK_DEPTH  = (CAPACITY + NUM_CELLS - 1) / NUM_CELLS;
   localparam int BANK_ADDR_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);

   // Compare stages of a cell; sets the delay that waits for the last compare result.
   localparam int CELL_STAGES = 3;

   // Field widths.
   localparam int COORD_W   = 16;
   localparam int CIRCLE_W  = 3 * COORD_W;
   localparam int SLOT_W    = 10;
   localparam int TOTAL_W   = 11;
   localparam int VERDICT_W = 2;

   // Overlap arithmetic: 100 * d^2 < 121 * (r1 + r2)^2, all exact.
   localparam int ABS_SQ_W   = 2 * COORD_W;
   localparam int DIST_SQ_W  = ABS_SQ_W + 1;
   localparam int RSUM_W     = COORD_W + 1;
   localparam int RSUM_SQ_W  = 2 * RSUM_W;
   localparam int CMP_W      = RSUM_SQ_W + 7;
   localparam int DIST_SCALE = 100;
   localparam int SUM_SCALE  = 121;

   // Configuration registers.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  REGION_RESET      = 16'd5120;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_PLACED  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_OVERLAP = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_FULL    = 2'd3;

   // One circle as kept in the store.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] r;
   } circle_type;

   // Request payload.
   typedef struct packed {
      logic [COORD_W-1:0] cand_x;
      logic [COORD_W-1:0] cand_y;
      logic [COORD_W-1:0] cand_r;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic                 placed;
      logic [VERDICT_W-1:0] verdict;
      logic [SLOT_W-1:0]    slot;
      logic [TOTAL_W-1:0]   stored_total;
   } rsp_type;

   // Scan token handed from cell to cell: a bank address and the number
   // of stored circles still ahead of this cell in that row.
   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic [BANK_ADDR_W-1:0] addr;
      logic [COUNT_W-1:0]     remaining;
   } tok_type;

   // Store write into one cell's bank.
   typedef struct packed {
      logic                   en;
      logic [BANK_ADDR_W-1:0] addr;
      circle_type             data;
   } wr_type;

endpackage

`default_nettype wire

FILE: rtl/cpc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/cpc_cell.sv
// One cell of the scan row: a bank of stored circles and an overlap comparator.
// Depends on cpc_pkg and cpc_ram.
`default_nettype none

module cpc_cell (
   input  logic                clock,
   input  logic                reset,
   input  cpc_pkg::circle_type cand,
   input  cpc_pkg::tok_type    tok_in,
   output cpc_pkg::tok_type    tok_out,
   input  logic                hit_in,
   output logic                hit_out,
   input  cpc_pkg::wr_type     wr
);

   logic [cpc_pkg::CIRCLE_W-1:0]   rd_data;
   cpc_pkg::circle_type            entry;
   cpc_pkg::tok_type               tok_out_ff, tok_out_in;
   logic                           live1_ff, live2_ff, live3_ff;
   logic [cpc_pkg::COORD_W-1:0]    dx_abs, dy_abs;
   logic [cpc_pkg::RSUM_W-1:0]     rsum;
   logic [cpc_pkg::ABS_SQ_W-1:0]   dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [cpc_pkg::RSUM_SQ_W-1:0]  rs2_ff, rs2_in;
   logic [cpc_pkg::DIST_SQ_W-1:0]  dist_sq;
   logic [cpc_pkg::CMP_W-1:0]      dist_ff, dist_in, lim_ff, lim_in;
   logic                           hit_out_ff, hit_out_in;

   // This cell's share of the store.
   cpc_ram #(
      .WIDTH (cpc_pkg::CIRCLE_W),
      .DEPTH (cpc_pkg::BANK_DEPTH)
   ) u_bank (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (tok_in.addr),
      .rd_data (rd_data)
   );

   assign entry = rd_data;

   // Pass the token on; one fewer stored circle lies ahead of the neighbor.
   always_comb begin
      tok_out_in = tok_in;
      if (tok_in.remaining != '0) begin
         tok_out_in.remaining = tok_in.remaining - 1'b1;
      end
   end

   // Squares of the centre offsets and of the radius sum.
   always_comb begin
      dx_abs = (cand.x >= entry.x) ? cand.x - entry.x : entry.x - cand.x;
      dy_abs = (cand.y >= entry.y) ? cand.y - entry.y : entry.y - cand.y;
      rsum   = cpc_pkg::RSUM_W'(cand.r) + cpc_pkg::RSUM_W'(entry.r);
      dx2_in = cpc_pkg::ABS_SQ_W'(dx_abs) * cpc_pkg::ABS_SQ_W'(dx_abs);
      dy2_in = cpc_pkg::ABS_SQ_W'(dy_abs) * cpc_pkg::ABS_SQ_W'(dy_abs);
      rs2_in = cpc_pkg::RSUM_SQ_W'(rsum) * cpc_pkg::RSUM_SQ_W'(rsum);
   end

   // Scaled distance and limit.
   always_comb begin
      dist_sq = cpc_pkg::DIST_SQ_W'(dx2_ff) + cpc_pkg::DIST_SQ_W'(dy2_ff);
      dist_in = cpc_pkg::CMP_W'(dist_sq) * cpc_pkg::CMP_W'(cpc_pkg::DIST_SCALE);
      lim_in  = cpc_pkg::CMP_W'(rs2_ff) * cpc_pkg::CMP_W'(cpc_pkg::SUM_SCALE);
   end

   // Compare and merge with the hits of the cells upstream.
   assign hit_out_in = hit_in | (live3_ff & (dist_ff < lim_ff));

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff.valid <= 1'b0;
         live1_ff         <= 1'b0;
         live2_ff         <= 1'b0;
         live3_ff         <= 1'b0;
         hit_out_ff       <= 1'b0;
      end else begin
         tok_out_ff.valid <= tok_out_in.valid;
         live1_ff         <= tok_in.valid & (tok_in.remaining != '0);
         live2_ff         <= live1_ff;
         live3_ff         <= live2_ff;
         hit_out_ff       <= hit_out_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      tok_out_ff.last      <= tok_out_in.last;
      tok_out_ff.addr      <= tok_out_in.addr;
      tok_out_ff.remaining <= tok_out_in.remaining;
      dx2_ff               <= dx2_in;
      dy2_ff               <= dy2_in;
      rs2_ff               <= rs2_in;
      dist_ff              <= dist_in;
      lim_ff               <= lim_in;
   end

   assign tok_out = tok_out_ff;
   assign hit_out = hit_out_ff;

endmodule

`default_nettype wire

FILE: rtl/circle_placement_checker.sv
// Top level of the circle placement checker: control, region check and cell row.
// Depends on cpc_pkg, cpc_cell and cpc_ram.
//
//   Channel   Ports                               Direction   Content
//   request   req_valid, req_stall, req_payload   in          candidate x, y, radius
//   response  rsp_valid, rsp_stall, rsp_payload   out         placed, verdict, slot, total
//   config    csr_we, csr_index, csr_wdata        in          region width and height
//
// A candidate outside the region, or one arriving at an empty store, goes
// from acceptance straight to the response. Otherwise the banks are swept:
// eight cells each read one entry of their bank per cycle, then the row
// depth and the three compare stages drain. One transaction is in work at
// a time; a finished response waits in the output register while the next
// request is taken.
// Reset is synchronous and needs no clearing pass; the store starts empty.
`default_nettype none

module circle_placement_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cpc_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cpc_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_we,
   input  logic [cpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cpc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   cpc_pkg::tok_type                   tok_ff, tok_in;
   cpc_pkg::circle_type                cand_ff, cand_in;
   logic                               outside_ff, outside_in;
   logic                               hit_acc_ff, hit_acc_in;
   logic [cpc_pkg::CELL_STAGES-1:0]    tail_dly_ff, tail_dly_in;
   logic [cpc_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [cpc_pkg::CSR_DATA_W-1:0]     width_ff, width_in, height_ff, height_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   cpc_pkg::rsp_type                   rsp_ff, rsp_in;

   cpc_pkg::tok_type                   tok_chain [cpc_pkg::NUM_CELLS+1];
   logic [cpc_pkg::NUM_CELLS:0]        hit_chain;
   cpc_pkg::wr_type                    wr_cell [cpc_pkg::NUM_CELLS];

   logic                               accept;
   logic                               outside_now;
   logic                               store_en;
   logic                               load_rsp;
   logic [cpc_pkg::VERDICT_W-1:0]      verdict;
   logic [cpc_pkg::COUNT_W-1:0]        rem_next;
   logic [cpc_pkg::CELL_SEL_W-1:0]     wr_sel;
   logic [cpc_pkg::BANK_ADDR_W-1:0]    wr_addr;

   assign req_stall = reset | (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // Region check: every edge of the circle must lie within the rectangle.
   always_comb begin
      outside_now = (req_payload.cand_x < req_payload.cand_r)
         || (req_payload.cand_y < req_payload.cand_r)
         || ((17'(req_payload.cand_x) + 17'(req_payload.cand_r)) > 17'(width_ff))
         || ((17'(req_payload.cand_y) + 17'(req_payload.cand_r)) > 17'(height_ff));
   end

   // Row of cells; the candidate is held steady while tokens sweep the banks.
   assign tok_chain[0] = tok_ff;
   assign hit_chain[0] = 1'b0;
   assign wr_sel  = cpc_pkg::CELL_SEL_W'(count_ff % cpc_pkg::NUM_CELLS);
   assign wr_addr = cpc_pkg::BANK_ADDR_W'(count_ff / cpc_pkg::NUM_CELLS);

   for (genvar i = 0; i < cpc_pkg::NUM_CELLS; i++) begin : g_cell
      assign wr_cell[i].en   = store_en & (wr_sel == cpc_pkg::CELL_SEL_W'(i));
      assign wr_cell[i].addr = wr_addr;
      assign wr_cell[i].data = cand_ff;

      cpc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cand    (cand_ff),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1]),
         .hit_in  (hit_chain[i]),
         .hit_out (hit_chain[i+1]),
         .wr      (wr_cell[i])
      );
   end

   // The last token leaving the row lines up with the last compare result.
   assign tail_dly_in = {tail_dly_ff[cpc_pkg::CELL_STAGES-2:0],
                         tok_chain[cpc_pkg::NUM_CELLS].valid
                         & tok_chain[cpc_pkg::NUM_CELLS].last};

   // Final verdict of the transaction in work.
   always_comb begin
      if (outside_ff) begin
         verdict = cpc_pkg::VERDICT_OUTSIDE;
      end else if (hit_acc_ff) begin
         verdict = cpc_pkg::VERDICT_OVERLAP;
      end else if (count_ff >= cpc_pkg::CAPACITY) begin
         verdict = cpc_pkg::VERDICT_FULL;
      end else begin
         verdict = cpc_pkg::VERDICT_PLACED;
      end
   end

   // Sequencer: accept, sweep the banks, wait for the row, respond.
   always_comb begin
      state_in   = state_ff;
      tok_in     = tok_ff;
      cand_in    = cand_ff;
      outside_in = outside_ff;
      hit_acc_in = hit_acc_ff | hit_chain[cpc_pkg::NUM_CELLS];
      count_in   = count_ff;
      store_en   = 1'b0;
      load_rsp   = 1'b0;
      rem_next   = tok_ff.remaining - cpc_pkg::COUNT_W'(cpc_pkg::NUM_CELLS);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cand_in.x  = req_payload.cand_x;
               cand_in.y  = req_payload.cand_y;
               cand_in.r  = req_payload.cand_r;
               outside_in = outside_now;
               hit_acc_in = 1'b0;
               if (outside_now || (count_ff == '0)) begin
                  state_in = ST_FINISH;
               end else begin
                  tok_in.valid     = 1'b1;
                  tok_in.last      = (count_ff <= cpc_pkg::NUM_CELLS);
                  tok_in.addr      = '0;
                  tok_in.remaining = count_ff;
                  state_in         = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (tok_ff.last) begin
               tok_in.valid = 1'b0;
               state_in     = ST_DRAIN;
            end else begin
               tok_in.addr      = tok_ff.addr + 1'b1;
               tok_in.remaining = rem_next;
               tok_in.last      = (rem_next <= cpc_pkg::NUM_CELLS);
            end
         end
         ST_DRAIN: begin
            if (tail_dly_ff[cpc_pkg::CELL_STAGES-1]) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
               if (verdict == cpc_pkg::VERDICT_PLACED) begin
                  store_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_in.placed       = (verdict == cpc_pkg::VERDICT_PLACED);
      rsp_in.verdict      = verdict;
      rsp_in.slot         = rsp_in.placed ? cpc_pkg::SLOT_W'(count_ff) : '0;
      rsp_in.stored_total = cpc_pkg::TOTAL_W'(count_in);
      rsp_valid_in        = load_rsp | (rsp_valid_ff & rsp_stall);
   end

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            cpc_pkg::REG_REGION_WIDTH:  width_in  = csr_wdata;
            cpc_pkg::REG_REGION_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tok_ff.valid <= 1'b0;
         tail_dly_ff  <= '0;
         count_ff     <= '0;
         width_ff     <= cpc_pkg::REGION_RESET;
         height_ff    <= cpc_pkg::REGION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tok_ff.valid <= tok_in.valid;
         tail_dly_ff  <= tail_dly_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tok_ff.last      <= tok_in.last;
      tok_ff.addr      <= tok_in.addr;
      tok_ff.remaining <= tok_in.remaining;
      cand_ff          <= cand_in;
      outside_ff       <= outside_in;
      hit_acc_ff       <= hit_acc_in;
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/cpc_checker.sv
// Port-level assertions for the circle placement checker, bound to the top level.
// Depends on cpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cpc_pkg::rsp_type rsp_payload
);

   // A stalled response stays valid and unchanged.
   `CPC_ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // The placed flag agrees with the verdict.
   `CPC_ASSERT_CLK(a_placed_code, rsp_valid |-> (rsp_payload.placed == (rsp_payload.verdict == cpc_pkg::VERDICT_PLACED)), "placed flag disagrees with verdict")

   // A rejected candidate reports slot zero.
   `CPC_ASSERT_CLK(a_reject_slot, rsp_valid && !rsp_payload.placed |-> rsp_payload.slot == '0, "rejected transaction reports a slot")

   // Only one transaction is in work: an accepted request stalls the next cycle.
   `CPC_ASSERT_CLK(a_one_in_work, req_valid && !req_stall |=> req_stall, "request accepted while busy")

endmodule

bind circle_placement_checker cpc_checker u_cpc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
